// ----- design/gcd_pkg.sv -----
package gcd_pkg;

    typedef logic signed [28:0] t_lon;
    typedef logic signed [27:0] t_lat;
    typedef logic [25:0]        t_dist;
    typedef logic [23:0]        t_radius;

    typedef struct packed {
        logic cos_mode;
        logic neg;
    } t_poly_ctl;

    localparam t_radius RADIUS_RESET = 24'd1013504;
    localparam t_dist   DIST_MAX     = 26'h3FFFFFF;

    localparam logic signed [31:0] Q30_ONE    = 32'sd1073741824;
    localparam logic [60:0]        Q60_ONE    = 61'd1 << 60;
    localparam logic [30:0]        HALF_PI    = 31'd1686629713;
    localparam logic signed [31:0] FOUR_TURNS = 32'sd1509949440;

    // Horner steps that divide by a non-trivial constant, then one final step
    localparam int POLY_DIVS  = 6;
    localparam int POLY_STEPS = POLY_DIVS + 1;
    localparam int POLY_LAT   = 1 + 3 * POLY_STEPS;

    localparam logic [7:0] DEN_SIN [POLY_DIVS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] DEN_COS [POLY_DIVS] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

    localparam logic [31:0] RCP_SIN [POLY_DIVS] = '{
        32'((64'd1 << 34) / 64'd156), 32'((64'd1 << 34) / 64'd110),
        32'((64'd1 << 34) / 64'd72),  32'((64'd1 << 34) / 64'd42),
        32'((64'd1 << 34) / 64'd20),  32'((64'd1 << 34) / 64'd6)
    };
    localparam logic [31:0] RCP_COS [POLY_DIVS] = '{
        32'((64'd1 << 34) / 64'd182), 32'((64'd1 << 34) / 64'd132),
        32'((64'd1 << 34) / 64'd90),  32'((64'd1 << 34) / 64'd56),
        32'((64'd1 << 34) / 64'd30),  32'((64'd1 << 34) / 64'd12)
    };

    localparam int SQRT_STEPS = 31;
    localparam int ASIN_BITS  = 31;
    localparam int LAT = 6 + POLY_LAT + 4 + SQRT_STEPS + 1 + ASIN_BITS * (POLY_LAT + 1) + 2;

endpackage

// ----- design/gcd_pts_if.sv -----
interface gcd_pts_if import gcd_pkg::*; ();
    logic valid;
    logic ready;
    t_lon first_longitude;
    t_lat first_latitude;
    t_lon second_longitude;
    t_lat second_latitude;

    modport source (
        output valid, output first_longitude, output first_latitude,
        output second_longitude, output second_latitude,
        input  ready
    );
    modport sink (
        input  valid, input first_longitude, input first_latitude,
        input  second_longitude, input second_latitude,
        output ready
    );
endinterface

// ----- design/gcd_dist_if.sv -----
interface gcd_dist_if import gcd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_dist distance;

    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

// ----- design/gcd_poly.sv -----
module gcd_poly import gcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_poly_ctl          i_ctl,
    input  logic [30:0]        i_r,
    output logic signed [31:0] o_val
);

    logic [31:0]        r_r2  [POLY_LAT];
    logic [30:0]        r_r   [POLY_LAT];
    t_poly_ctl          r_ctl [POLY_LAT];
    logic [33:0]        r_mx  [POLY_STEPS];
    logic               r_sg  [POLY_STEPS];
    logic [33:0]        r_q   [POLY_STEPS];
    logic [33:0]        r_mx2 [POLY_STEPS];
    logic               r_sg2 [POLY_STEPS];
    logic signed [31:0] r_t   [POLY_STEPS];
    logic [61:0]        w_rr;

    assign w_rr = 62'(i_r) * 62'(i_r);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2[0]  <= w_rr[61:30];
            r_r[0]   <= i_r;
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < POLY_LAT; s++) begin
                r_r2[s]  <= r_r2[s-1];
                r_r[s]   <= r_r[s-1];
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    for (genvar j = 0; j < POLY_STEPS; j++) begin : g_step
        localparam int S1 = 1 + 3 * j;
        localparam int S2 = S1 + 1;
        localparam int S3 = S1 + 2;

        logic signed [31:0] w_t_in;
        logic [31:0]        w_opnd;
        logic signed [64:0] w_p;
        logic [64:0]        w_mag;
        logic [33:0]        w_q_nx;
        logic signed [31:0] w_t_nx;

        if (j == 0) begin : g_first
            assign w_t_in = Q30_ONE;
        end else begin : g_next
            assign w_t_in = r_t[j-1];
        end

        // last sine step multiplies by r instead of r^2
        assign w_opnd = (j == POLY_DIVS && !r_ctl[S1-1].cos_mode) ?
                        {1'b0, r_r[S1-1]} : r_r2[S1-1];
        assign w_p    = $signed({1'b0, w_opnd}) * w_t_in;
        assign w_mag  = w_p[64] ? 65'(-w_p) : 65'(w_p);

        if (j < POLY_DIVS) begin : g_div
            logic [31:0] w_m;
            logic [7:0]  w_d;
            logic [65:0] w_qp;
            logic [33:0] w_rem;
            logic [33:0] w_q;

            assign w_m    = r_ctl[S2-1].cos_mode ? RCP_COS[j] : RCP_SIN[j];
            assign w_qp   = 66'(r_mx[j]) * 66'(w_m);
            assign w_q_nx = 34'(w_qp[65:34]);
            assign w_d    = r_ctl[S3-1].cos_mode ? DEN_COS[j] : DEN_SIN[j];
            assign w_rem  = r_mx2[j] - r_q[j] * 34'(w_d);
            assign w_q    = r_q[j] + 34'(w_rem >= 34'(w_d));
            assign w_t_nx = r_sg2[j] ? Q30_ONE + 32'(w_q) : Q30_ONE - 32'(w_q);
        end else begin : g_last
            logic signed [31:0] w_v;

            assign w_q_nx = r_ctl[S2-1].cos_mode ? (r_mx[j] >> 1) : r_mx[j];
            always_comb begin
                if (r_ctl[S3-1].cos_mode) begin
                    w_v = r_sg2[j] ? Q30_ONE + 32'(r_q[j]) : Q30_ONE - 32'(r_q[j]);
                end else begin
                    w_v = r_sg2[j] ? -32'(r_q[j]) : 32'(r_q[j]);
                end
            end
            assign w_t_nx = r_ctl[S3-1].neg ? -w_v : w_v;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mx[j]  <= w_mag[63:30];
                r_sg[j]  <= w_p[64];
                r_q[j]   <= w_q_nx;
                r_mx2[j] <= r_mx[j];
                r_sg2[j] <= r_sg[j];
                r_t[j]   <= w_t_nx;
            end
        end
    end

    assign o_val = r_t[POLY_STEPS-1];

endmodule

// ----- design/great_circle_distance.sv -----
// Haversine great circle distance, fully pipelined.
// The pipeline depth is dominated by 31 arcsine bit steps of 23 stages
// each, each step running one sine series pipeline.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears all valid bits and loads the radius
// register with 1013504; data registers are not reset.
module great_circle_distance import gcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_radius    i_cfg_data,
    gcd_pts_if.sink    i_pts,
    gcd_dist_if.source o_dist
);

    localparam int ST_H4  = 6 + POLY_LAT + 3;
    localparam int ST_ARG = ST_H4 + SQRT_STEPS + 1;
    localparam logic [30:0] ARG_MAX = 31'd759250124;
    localparam logic [30:0] DIV45   = 31'd45;
    localparam logic [30:0] M45     = 31'((64'd1 << 36) / 64'd45);
    localparam logic [30:0] M45S    = 31'((64'd1 << 21) / 64'd45);

    function automatic logic signed [31:0] q30_trunc(input logic signed [63:0] p);
        logic [63:0] mag;
        mag = p[63] ? 64'(-p) : 64'(p);
        return p[63] ? -$signed(32'(mag >> 30)) : $signed(32'(mag >> 30));
    endfunction

    logic               w_en;
    logic [LAT-1:0]     r_vld;
    t_radius            r_radius;
    logic signed [31:0] w_n    [4];
    logic signed [31:0] w_trig [4];

    assign w_en        = !r_vld[LAT-1] || o_dist.ready;
    assign i_pts.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RADIUS_RESET;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_pts.valid};
            end
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    // angles plus four turns, never negative
    assign w_n[0] = 32'(i_pts.first_latitude) - 32'(i_pts.second_latitude) + FOUR_TURNS;
    assign w_n[1] = 32'(i_pts.first_longitude) - 32'(i_pts.second_longitude) + FOUR_TURNS;
    assign w_n[2] = 32'(i_pts.first_latitude) + FOUR_TURNS;
    assign w_n[3] = 32'(i_pts.second_latitude) + FOUR_TURNS;

    // lanes 0,1: sine of half differences; lanes 2,3: cosine of latitudes
    for (genvar g = 0; g < 4; g++) begin : g_lane
        localparam bit FULL = (g >= 2);

        logic [30:0] r_n, r_n2, r_r6;
        logic [25:0] r_q45, r_a3, r_a4;
        logic [14:0] r_u3, r_u4;
        logic [9:0]  r_v4;
        logic [1:0]  r_quad;
        logic [29:0] r_f;
        t_poly_ctl   r_ctl6;
        logic [61:0] w_p2;
        logic [30:0] w_rem3;
        logic        w_ge3;
        logic [5:0]  w_b3;
        logic [14:0] w_u3;
        logic [30:0] w_p4;
        logic [14:0] w_rem5;
        logic [9:0]  w_v5;
        logic [31:0] w_ph;
        logic [60:0] w_p6;

        assign w_p2   = 62'(r_n) * 62'(M45);
        assign w_rem3 = r_n2 - 31'(r_q45) * DIV45;
        assign w_ge3  = w_rem3 >= DIV45;
        assign w_b3   = w_ge3 ? 6'(w_rem3 - DIV45) : 6'(w_rem3);
        assign w_u3   = FULL ? 15'({w_b3, 9'd0}) + 15'd22 : 15'({w_b3, 8'd0}) + 15'd22;
        assign w_p4   = 31'(r_u3) * M45S;
        assign w_rem5 = r_u4 - 15'(r_v4) * 15'(DIV45);
        assign w_v5   = r_v4 + 10'(w_rem5 >= 15'(DIV45));
        assign w_ph   = FULL ? 32'({r_a4, 9'd0}) + 32'(w_v5) : 32'({r_a4, 8'd0}) + 32'(w_v5);
        assign w_p6   = 61'(r_f) * 61'(HALF_PI);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_n    <= w_n[g][30:0];
                r_q45  <= w_p2[61:36];
                r_n2   <= r_n;
                r_a3   <= r_q45 + 26'(w_ge3);
                r_u3   <= w_u3;
                r_a4   <= r_a3;
                r_u4   <= r_u3;
                r_v4   <= w_p4[30:21];
                // cosine is sine a quarter turn ahead
                r_quad <= w_ph[31:30] + 2'(FULL);
                r_f    <= w_ph[29:0];
                r_r6   <= w_p6[60:30];
                r_ctl6 <= '{cos_mode: r_quad[0], neg: r_quad[1]};
            end
        end

        gcd_poly u_poly (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ctl (r_ctl6),
            .i_r   (r_r6),
            .o_val (w_trig[g])
        );
    end

    // h = sa^2 + cos1*cos2*sb^2, clamped to [0, 1]
    logic signed [31:0] r_cp, r_sb1, r_m1, r_sb2;
    logic signed [63:0] r_sa2_1, r_sa2_2, r_sa2_3, r_pr;
    logic [60:0]        r_hy, r_hz, w_hu;
    logic signed [64:0] w_h;

    assign w_h = 65'(r_sa2_3) + 65'(r_pr);

    always_comb begin
        if (w_h[64]) begin
            w_hu = '0;
        end else if (w_h[63:0] > 64'(Q60_ONE)) begin
            w_hu = Q60_ONE;
        end else begin
            w_hu = w_h[60:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cp    <= q30_trunc(64'(w_trig[2]) * 64'(w_trig[3]));
            r_sa2_1 <= 64'(w_trig[0]) * 64'(w_trig[0]);
            r_sb1   <= w_trig[1];
            r_m1    <= q30_trunc(64'(r_cp) * 64'(r_sb1));
            r_sa2_2 <= r_sa2_1;
            r_sb2   <= r_sb1;
            r_pr    <= 64'(r_m1) * 64'(r_sb2);
            r_sa2_3 <= r_sa2_2;
            r_hy    <= w_hu;
            r_hz    <= Q60_ONE - w_hu;
        end
    end

    // two digit-by-digit square roots, one result bit per stage
    logic [60:0] r_sv [2][SQRT_STEPS];
    logic [61:0] r_sr [2][SQRT_STEPS];

    for (genvar l = 0; l < 2; l++) begin : g_sqrt
        for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_it
            localparam logic [61:0] BIT = 62'd1 << (60 - 2 * i);

            logic [60:0] w_v_in;
            logic [61:0] w_r_in, w_t;

            if (i == 0) begin : g_head
                assign w_v_in = (l == 0) ? r_hy : r_hz;
                assign w_r_in = '0;
            end else begin : g_body
                assign w_v_in = r_sv[l][i-1];
                assign w_r_in = r_sr[l][i-1];
            end
            assign w_t = w_r_in + BIT;

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if ({1'b0, w_v_in} >= w_t) begin
                        r_sv[l][i] <= w_v_in - w_t[60:0];
                        r_sr[l][i] <= (w_r_in >> 1) + BIT;
                    end else begin
                        r_sv[l][i] <= w_v_in;
                        r_sr[l][i] <= w_r_in >> 1;
                    end
                end
            end
        end
    end

    // arcsine of the smaller root keeps the search well conditioned
    logic [30:0] r_arg, w_y, w_z;
    logic        r_flip;

    assign w_y = r_sr[0][SQRT_STEPS-1][30:0];
    assign w_z = r_sr[1][SQRT_STEPS-1][30:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_arg  <= (w_y <= w_z) ? w_y : w_z;
            r_flip <= w_y > w_z;
        end
    end

    logic [30:0] r_lo_o   [ASIN_BITS];
    logic [30:0] r_arg_o  [ASIN_BITS];
    logic        r_flip_o [ASIN_BITS];

    for (genvar k = 0; k < ASIN_BITS; k++) begin : g_asin
        localparam logic [30:0] BITM = 31'd1 << (ASIN_BITS - 1 - k);

        logic [30:0]        w_lo_in, w_arg_in, w_cand;
        logic               w_flip_in, w_take;
        logic signed [31:0] w_s;
        logic [30:0]        r_dlo   [POLY_LAT];
        logic [30:0]        r_darg  [POLY_LAT];
        logic               r_dflip [POLY_LAT];

        if (k == 0) begin : g_head
            assign w_lo_in   = '0;
            assign w_arg_in  = r_arg;
            assign w_flip_in = r_flip;
        end else begin : g_body
            assign w_lo_in   = r_lo_o[k-1];
            assign w_arg_in  = r_arg_o[k-1];
            assign w_flip_in = r_flip_o[k-1];
        end

        gcd_poly u_poly (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ctl ('{cos_mode: 1'b0, neg: 1'b0}),
            .i_r   (w_lo_in | BITM),
            .o_val (w_s)
        );

        assign w_cand = r_dlo[POLY_LAT-1] | BITM;
        assign w_take = (w_cand <= HALF_PI) &&
                        (w_s <= $signed({1'b0, r_darg[POLY_LAT-1]}));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dlo[0]   <= w_lo_in;
                r_darg[0]  <= w_arg_in;
                r_dflip[0] <= w_flip_in;
                for (int s = 1; s < POLY_LAT; s++) begin
                    r_dlo[s]   <= r_dlo[s-1];
                    r_darg[s]  <= r_darg[s-1];
                    r_dflip[s] <= r_dflip[s-1];
                end
                r_lo_o[k]   <= w_take ? w_cand : r_dlo[POLY_LAT-1];
                r_arg_o[k]  <= r_darg[POLY_LAT-1];
                r_flip_o[k] <= r_dflip[POLY_LAT-1];
            end
        end
    end

    // scale by radius, round, saturate
    logic [30:0] w_theta;
    logic [54:0] r_prod;
    logic [55:0] w_rnd;
    t_dist       r_dist;

    assign w_theta = r_flip_o[ASIN_BITS-1] ? HALF_PI - r_lo_o[ASIN_BITS-1]
                                            : r_lo_o[ASIN_BITS-1];
    assign w_rnd   = 56'(r_prod) + (56'd1 << 28);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= 55'(w_theta) * 55'(r_radius);
            r_dist <= (w_rnd[55:29] > 27'(DIST_MAX)) ? DIST_MAX : w_rnd[54:29];
        end
    end

    assign o_dist.valid    = r_vld[LAT-1];
    assign o_dist.distance = r_dist;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pts.valid && i_pts.ready |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_h_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_H4] |-> r_hy <= Q60_ONE)
        else $error("haversine term above one");

    a_arg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_ARG] |-> r_arg <= ARG_MAX)
        else $error("arcsine argument above sqrt of one half");

endmodule
